// ----- hdl/lzss_stream_decoder_defines.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef LZSS_STREAM_DECODER_DEFINES_SVH
`define LZSS_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge while reset is released.
`define LZSD_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked at every rising clock edge, reset included.
`define LZSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LZSD_ASSERT(label, clk, rstn, prop, msg)
`define LZSD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hdl/lzsd_pkg.sv -----
package lzsd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 4096;
  localparam int unsigned COUNT_WIDTH_DEF  = 24;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned COPY_LEN_W = 5;
  localparam int unsigned FLAG_POS_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BIAS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] BIAS_RESET = 4'd1;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_HIGH,
    PH_COPY
  } phase_e;

endpackage

// ----- hdl/lzss_stream_decoder.sv -----
// A literal reaches the output in the cycle after its request is taken; a reference gives
// its first byte via the history read, read data stage and output register, then one byte
// per cycle while the output is not stalled. Flag, literal and low bytes are taken one
// request per cycle while the output is not stalled; a reference holds the input until its
// copy is done (single history read port). Reset (rst_ni low, or a total_length write)
// clears control state at once; history is not swept, entries unwritten this run read zero.
`include "lzss_stream_decoder_defines.svh"

module lzss_stream_decoder
  import lzsd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [BYTE_W-1:0]     s_axis_tdata_i,   // [7:0] in_byte

  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [BYTE_W-1:0]     m_axis_tdata_o,   // [7:0] out_byte
  output logic                  m_axis_tlast_o,   // run_last
  output logic [0:0]            m_axis_tuser_o    // [0] stream_last
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  // Token control.
  phase_e                  state_q, state_d;
  logic [BYTE_W-1:0]       flags_q, flags_d;
  logic [FLAG_POS_W-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0]       ref_lo_q, ref_lo_d;
  logic [LEN_W-1:0]        bias_q, bias_d;
  logic [COUNT_WIDTH-1:0]  total_q, total_d;
  logic [COUNT_WIDTH-1:0]  count_q, count_d;
  logic [AW-1:0]           widx_q, widx_d;
  logic                    full_q, full_d;
  logic                    finished_q, finished_d;

  // Copy read side.
  logic [AW-1:0]           src_q, src_d;
  logic [COPY_LEN_W-1:0]   rem_q, rem_d;

  // Read data stage.
  logic                    b_valid_q, b_valid_d;
  logic                    b_last_q, b_last_d;
  logic                    b_fwd_q, b_fwd_d;
  logic                    b_zero_q, b_zero_d;
  logic [BYTE_W-1:0]       b_fwd_data_q, b_fwd_data_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]       out_byte_q, out_byte_d;
  logic                    out_run_last_q, out_run_last_d;
  logic                    out_stream_last_q, out_stream_last_d;

  logic [BYTE_W-1:0]       hist_mem [WINDOW_DEPTH];
  logic [BYTE_W-1:0]       mem_rdata_q;

  logic                    can_emit;
  logic                    in_fire;
  logic                    cfg_fire;
  logic                    restart;
  logic                    cur_bit;
  logic                    lit_fire;
  logic                    copy_emit;
  logic                    emit;
  logic [BYTE_W-1:0]       b_byte;
  logic [BYTE_W-1:0]       emit_byte;
  logic [COUNT_WIDTH-1:0]  count_inc;
  logic                    stream_last;
  logic                    issue;
  logic                    copy_done;
  logic [AW-1:0]           distance;
  logic [COUNT_WIDTH-1:0]  cfg_total;

  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;
  assign restart         = cfg_fire && (cfg_index_i == REG_TOTAL_LENGTH);
  assign cfg_total       = COUNT_WIDTH'(cfg_data_i);

  assign can_emit        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q != PH_COPY) && can_emit;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign cur_bit   = flags_q[pos_q];
  assign lit_fire  = in_fire && !finished_q && (state_q == PH_TOKEN) && cur_bit;
  assign b_byte    = b_fwd_q ? b_fwd_data_q : (b_zero_q ? '0 : mem_rdata_q);
  assign copy_emit = b_valid_q && can_emit && !finished_q;
  assign emit      = lit_fire || copy_emit;
  assign emit_byte = copy_emit ? b_byte : s_axis_tdata_i;

  assign count_inc   = count_q + COUNT_WIDTH'(1);
  assign stream_last = (count_inc == total_q);

  // A read may go out when the data stage is free or drains this cycle; none goes out
  // behind the final byte of the stream.
  assign issue = (state_q == PH_COPY) && (rem_q != '0) && (!b_valid_q || can_emit)
                 && !(copy_emit && stream_last);
  assign copy_done = copy_emit && (b_last_q || stream_last);

  // The 12-bit distance field sits in the high byte and the upper nibble of the low byte.
  assign distance = AW'({s_axis_tdata_i, ref_lo_q[BYTE_W-1:LEN_W]});

  // Next state.
  always_comb begin
    state_d = state_q;
    if (restart) begin
      state_d = PH_FLAG;
    end else if (in_fire && !finished_q) begin
      unique case (state_q)
        PH_FLAG:  state_d = PH_TOKEN;
        PH_TOKEN: begin
          if (!cur_bit) begin
            state_d = PH_HIGH;
          end else if (pos_q == '1) begin
            state_d = PH_FLAG;
          end
        end
        PH_HIGH:  state_d = PH_COPY;
        PH_COPY:  state_d = PH_COPY;
        default:  state_d = PH_FLAG;
      endcase
    end else if (state_q == PH_COPY && copy_done) begin
      state_d = (pos_q == '1) ? PH_FLAG : PH_TOKEN;
    end
  end

  // Datapath and output next values.
  always_comb begin
    flags_d           = flags_q;
    pos_d             = pos_q;
    ref_lo_d          = ref_lo_q;
    bias_d            = bias_q;
    total_d           = total_q;
    count_d           = count_q;
    widx_d            = widx_q;
    full_d            = full_q;
    finished_d        = finished_q;
    src_d             = src_q;
    rem_d             = rem_q;
    b_valid_d         = b_valid_q;
    b_last_d          = b_last_q;
    b_fwd_d           = b_fwd_q;
    b_zero_d          = b_zero_q;
    b_fwd_data_d      = b_fwd_data_q;
    out_valid_d       = out_valid_q;
    out_byte_d        = out_byte_q;
    out_run_last_d    = out_run_last_q;
    out_stream_last_d = out_stream_last_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (emit) begin
      widx_d            = widx_q + AW'(1);
      full_d            = full_q || (widx_q == '1);
      count_d           = count_inc;
      finished_d        = finished_q || stream_last;
      out_valid_d       = 1'b1;
      out_byte_d        = emit_byte;
      out_run_last_d    = lit_fire || b_last_q || stream_last;
      out_stream_last_d = stream_last;
    end

    if (in_fire && !finished_q) begin
      unique case (state_q)
        PH_FLAG: begin
          flags_d = s_axis_tdata_i;
          pos_d   = '0;
        end
        PH_TOKEN: begin
          if (cur_bit) begin
            pos_d = pos_q + FLAG_POS_W'(1);
          end else begin
            ref_lo_d = s_axis_tdata_i;
          end
        end
        PH_HIGH: begin
          src_d = widx_q - distance - AW'(1);
          rem_d = COPY_LEN_W'(ref_lo_q[LEN_W-1:0]) + COPY_LEN_W'(bias_q) + COPY_LEN_W'(1);
        end
        PH_COPY: begin
          rem_d = rem_q;
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end

    if (issue) begin
      src_d        = src_q + AW'(1);
      rem_d        = rem_q - COPY_LEN_W'(1);
      b_valid_d    = 1'b1;
      b_last_d     = (rem_q == COPY_LEN_W'(1));
      // The byte written this cycle has not reached the memory array yet.
      b_fwd_d      = copy_emit && (src_q == widx_q);
      b_zero_d     = !full_q && (src_q >= widx_q);
      b_fwd_data_d = b_byte;
    end else if (copy_emit) begin
      b_valid_d = 1'b0;
    end

    if (copy_done) begin
      pos_d = pos_q + FLAG_POS_W'(1);
      rem_d = '0;
    end

    if (cfg_fire && cfg_index_i == REG_LENGTH_BIAS) begin
      bias_d = cfg_data_i[LEN_W-1:0];
    end

    if (restart) begin
      total_d    = cfg_total;
      finished_d = (cfg_total == '0);
      flags_d    = '0;
      pos_d      = '0;
      ref_lo_d   = '0;
      count_d    = '0;
      widx_d     = '0;
      full_d     = 1'b0;
      rem_d      = '0;
      b_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= PH_FLAG;
      flags_q           <= '0;
      pos_q             <= '0;
      ref_lo_q          <= '0;
      bias_q            <= BIAS_RESET;
      total_q           <= COUNT_WIDTH'(1);
      count_q           <= '0;
      widx_q            <= '0;
      full_q            <= 1'b0;
      finished_q        <= 1'b0;
      src_q             <= '0;
      rem_q             <= '0;
      b_valid_q         <= 1'b0;
      b_last_q          <= 1'b0;
      b_fwd_q           <= 1'b0;
      b_zero_q          <= 1'b0;
      out_valid_q       <= 1'b0;
      out_run_last_q    <= 1'b0;
      out_stream_last_q <= 1'b0;
    end else begin
      state_q           <= state_d;
      flags_q           <= flags_d;
      pos_q             <= pos_d;
      ref_lo_q          <= ref_lo_d;
      bias_q            <= bias_d;
      total_q           <= total_d;
      count_q           <= count_d;
      widx_q            <= widx_d;
      full_q            <= full_d;
      finished_q        <= finished_d;
      src_q             <= src_d;
      rem_q             <= rem_d;
      b_valid_q         <= b_valid_d;
      b_last_q          <= b_last_d;
      b_fwd_q           <= b_fwd_d;
      b_zero_q          <= b_zero_d;
      out_valid_q       <= out_valid_d;
      out_run_last_q    <= out_run_last_d;
      out_stream_last_q <= out_stream_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_fwd_data_q <= b_fwd_data_d;
    out_byte_q   <= out_byte_d;
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      hist_mem[widx_q] <= emit_byte;
    end
    if (issue) begin
      mem_rdata_q <= hist_mem[src_q];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_run_last_q;
  assign m_axis_tuser_o  = out_stream_last_q;

  `LZSD_ASSERT(a_end_sets_finished, clk_i, rst_ni,
               (emit && stream_last && !restart) |=> finished_q,
               "stream end did not set finished")
  `LZSD_ASSERT(a_no_read_when_finished, clk_i, rst_ni,
               issue |-> !finished_q,
               "history read issued after stream end")
  `LZSD_ASSERT_ALWAYS(a_stage_in_copy, clk_i,
                      (rst_ni && b_valid_q) |-> (state_q == PH_COPY),
                      "read data pending outside a copy")

endmodule
